[design/assert_macros.svh]
// assertion macros shared by the life row stepper files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/lgrs_pkg.sv]
// package: constants, types and the life rule for the row stepper
`default_nettype none
package lgrs_pkg;

    localparam int COLS       = 64;
    localparam int CFG_W      = 7;
    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(50);
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    // masked bits one cell hands to its neighbors
    typedef struct packed {
        logic above;
        logic held;
        logic cur;
    } t_lane;

    // control shared by every cell of the row
    typedef struct packed {
        logic take;
        logic last;
        logic row_held;
    } t_cell_ctl;

    typedef struct packed {
        logic [COLS-1:0] next_row;
        logic            grid_done;
    } t_result;

    // birth on three, survival on two or three
    function automatic logic life_rule(input logic alive, input logic [7:0] nb);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(nb[i]);
        end
        return (n == 4'd3) || (alive && (n == 4'd2));
    endfunction

endpackage
`default_nettype wire

[design/lgrs_if.sv]
// handshake channels: row input, result output, width configuration
`default_nettype none
interface lgrs_row_if;
    import lgrs_pkg::*;
    logic            valid;
    logic            ready;
    logic [COLS-1:0] row_cells;
    logic            last_row;
    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgrs_res_if;
    import lgrs_pkg::*;
    logic            valid;
    logic            ready;
    logic [COLS-1:0] next_row;
    logic            grid_done;
    modport source (output valid, output next_row, output grid_done, input ready);
    modport sink   (input valid, input next_row, input grid_done, output ready);
endinterface

interface lgrs_cfg_if;
    import lgrs_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] cols_in_use;
    modport source (output valid, output cols_in_use, input ready);
    modport sink   (input valid, input cols_in_use, output ready);
endinterface
`default_nettype wire

[design/lgrs_cell.sv]
// one column cell: holds the above and held bits, computes both candidate results
`default_nettype none
module lgrs_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lgrs_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_mask,
    input  wire logic              i_cur,
    input  wire lgrs_pkg::t_lane   i_left,
    input  wire lgrs_pkg::t_lane   i_right,
    output lgrs_pkg::t_lane        o_lane,
    output logic                   o_gen_mid,
    output logic                   o_gen_last
);
    import lgrs_pkg::*;

    logic r_above, n_above;
    logic r_held,  n_held;
    logic up_l, up_s, up_r;

    assign o_lane.above = r_above & i_mask;
    assign o_lane.held  = r_held  & i_mask;
    assign o_lane.cur   = i_cur   & i_mask;

    // held row with the new row below it
    assign o_gen_mid = i_mask & life_rule(o_lane.held,
        {i_left.above, o_lane.above, i_right.above,
         i_left.held, i_right.held,
         i_left.cur, o_lane.cur, i_right.cur});

    // final row with a dead row below; its upper row is whatever is above it after the shift
    assign up_l = i_ctl.row_held ? i_left.held  : i_left.above;
    assign up_s = i_ctl.row_held ? o_lane.held  : o_lane.above;
    assign up_r = i_ctl.row_held ? i_right.held : i_right.above;
    assign o_gen_last = i_mask & life_rule(o_lane.cur,
        {up_l, up_s, up_r, i_left.cur, i_right.cur, 3'b000});

    always_comb begin
        n_above = r_above;
        n_held  = r_held;
        if (i_ctl.take) begin
            if (i_ctl.last) begin
                n_above = 1'b0;
                n_held  = 1'b0;
            end else begin
                if (i_ctl.row_held) begin
                    n_above = r_held;
                end
                n_held = i_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= 1'b0;
            r_held  <= 1'b0;
        end else begin
            r_above <= n_above;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

[design/lgrs_out_fifo.sv]
// result queue: takes up to two beats per cycle, delivers one
`default_nettype none
`include "assert_macros.svh"
module lgrs_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_n,
    input  wire lgrs_pkg::t_result i_push0,
    input  wire lgrs_pkg::t_result i_push1,
    output logic                   o_room2,
    output logic                   o_valid,
    output lgrs_pkg::t_result      o_data,
    input  wire logic              i_pop
);
    import lgrs_pkg::*;

    t_result              r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wptr, n_wptr;
    logic [OQ_PTR_W-1:0]  r_rptr, n_rptr;
    logic [OQ_CNT_W-1:0]  r_count, n_count;
    logic                 pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room2 = (r_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr + OQ_PTR_W'(i_push_n);
        n_rptr  = r_rptr + OQ_PTR_W'(pop_ok);
        n_count = r_count + OQ_CNT_W'(i_push_n) - OQ_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_push0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wptr + OQ_PTR_W'(1)] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= OQ_CNT_W'(OQ_DEPTH))
    `ASSERT_SAME(a_push_has_room, i_clk, i_rst_n, i_push_n != 2'd0, o_room2)
    `ASSERT_SAME(a_push_n_legal, i_clk, i_rst_n, 1'b1, i_push_n != 2'd3)

endmodule
`default_nettype wire

[design/life_generation_row_stepper.sv]
// Row stepper for one generation of Life (B3/S23) over a grid with a dead border.
// One row is taken per clock whenever the four-beat result queue has room for two
// beats; each row is handled by a chain of 64 column cells, each holding its column
// of the row above and the held row and trading masked bits with both neighbors,
// so the held row's result is formed as its lower neighbor arrives and is queued.
// The final row of a grid yields two beats in the same cycle, so the output side
// sets the sustained rate: one beat per cycle while the sink is ready, N beats per
// grid of N rows. Columns at or above cols_in_use are dead and read as zero.
`default_nettype none
`include "assert_macros.svh"
module life_generation_row_stepper (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lgrs_row_if.sink    i_row,
    lgrs_cfg_if.sink    i_cfg,
    lgrs_res_if.source  o_res
);
    import lgrs_pkg::*;

    logic [CFG_W-1:0] r_cols_in_use;
    logic             r_row_held, n_row_held;
    logic             take;
    logic             room2;
    t_cell_ctl        ctl;
    t_lane            lanes [COLS];
    logic [COLS-1:0]  lane_mask;
    logic [COLS-1:0]  gen_mid;
    logic [COLS-1:0]  gen_last;
    logic [1:0]       push_n;
    t_result          push0, push1, head;

    assign i_cfg.ready = 1'b1;
    assign i_row.ready = room2;
    assign take        = i_row.valid && room2;

    assign ctl.take     = take;
    assign ctl.last     = i_row.last_row;
    assign ctl.row_held = r_row_held;

    for (genvar c = 0; c < COLS; c++) begin : g_cell
        t_lane left_nb, right_nb;
        assign lane_mask[c] = CFG_W'(c) < r_cols_in_use;
        if (c == 0) begin : g_l
            assign left_nb = '0;
        end else begin : g_l
            assign left_nb = lanes[c-1];
        end
        if (c == COLS - 1) begin : g_r
            assign right_nb = '0;
        end else begin : g_r
            assign right_nb = lanes[c+1];
        end
        lgrs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_mask     (lane_mask[c]),
            .i_cur      (i_row.row_cells[c]),
            .i_left     (left_nb),
            .i_right    (right_nb),
            .o_lane     (lanes[c]),
            .o_gen_mid  (gen_mid[c]),
            .o_gen_last (gen_last[c])
        );
    end

    // held row goes out first, then the final row when flagged
    always_comb begin
        push_n          = 2'd0;
        push1.next_row  = gen_last;
        push1.grid_done = 1'b1;
        if (r_row_held) begin
            push0.next_row  = gen_mid;
            push0.grid_done = 1'b0;
        end else begin
            push0 = push1;
        end
        if (take) begin
            push_n = 2'(r_row_held) + 2'(i_row.last_row);
        end
    end

    always_comb begin
        n_row_held = r_row_held;
        if (take) begin
            n_row_held = !i_row.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_held    <= 1'b0;
            r_cols_in_use <= COLS_RESET;
        end else begin
            r_row_held <= n_row_held;
            if (i_cfg.valid) begin
                r_cols_in_use <= i_cfg.cols_in_use;
            end
        end
    end

    lgrs_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_push0  (push0),
        .i_push1  (push1),
        .o_room2  (room2),
        .o_valid  (o_res.valid),
        .o_data   (head),
        .i_pop    (o_res.ready)
    );

    assign o_res.next_row  = head.next_row;
    assign o_res.grid_done = head.grid_done;

    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, take && i_row.last_row, !r_row_held)
    `ASSERT_NEXT(a_row_kept, i_clk, i_rst_n, take && !i_row.last_row, r_row_held)
    `ASSERT_SAME(a_no_push_idle, i_clk, i_rst_n, !take, push_n == 2'd0)

endmodule
`default_nettype wire
